/* hw/rtl/fam_pkg.sv */
`default_nettype none

package fam_pkg;

  // Sync pair that opens a frame.
  localparam logic [7:0] SYNC_FIRST  = 8'h62;  // 'b'
  localparam logic [7:0] SYNC_SECOND = 8'h64;  // 'd'

  // Frame layout, counted from the first class byte.
  localparam int HEAD_BYTES  = 4;   // class id and length
  localparam int TRAIL_BYTES = 2;   // checksum, counted only
  localparam int HEAD_DEPTH  = 12;  // payload bytes kept for the angle words
  localparam int HEAD_IDX_W  = $clog2(HEAD_DEPTH);
  localparam int COUNT_W     = 17;
  localparam int ANGLE_W     = 32;

  // Class id that carries roll, pitch and yaw.
  localparam logic [15:0] CLASS_ANGLES = 16'h0000;

  typedef struct packed {
    logic [15:0]               frame_class;
    logic                      angles_updated;
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/framed_attitude_message_deframer.sv */
`default_nettype none

// Attitude message deframer for a serial byte stream.
// Input channel: in_valid / in_ready carry one received word (rx_byte) per
// handshake. Output channel: out_valid / out_ready carry one result per
// completed frame: frame_class, angles_updated and the held roll, pitch and
// yaw words after that frame.
// Frames: sync 'b','d', class id (low byte first), length (low byte first),
// payload, two checksum words (counted, not checked). A class id of zero
// reloads the angles from frame words 4-15, little-endian signed.
// Each taken word waits in the input register and is parsed from there; the
// word that ends a frame loads its result into the output register as it is parsed.
// Throughput: one word per cycle while no frame-ending word waits on the output.
// Stall: while a result waits, bytes that do not end a frame keep flowing;
// a frame-ending word holds in the input register until the output
// register frees, and in_ready drops only then.
// Reset (rst, synchronous): return to the hunt, clear the stored payload
// head and angle words, and drop both valid flags.
module framed_attitude_message_deframer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             frame_class,
  output logic                    angles_updated,
  output logic signed [31:0]      roll_out,
  output logic signed [31:0]      pitch_out,
  output logic signed [31:0]      yaw_out
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              emit;
  logic              fire;
  logic              out_free;
  fam_pkg::result_t  result;
  fam_pkg::result_t  held;

  // Advance the parser unless the word would emit into a busy output.
  assign out_free = !out_valid || out_ready;
  assign fire     = in_full && (!emit || out_free);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  fam_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .rx_byte (in_byte),
    .result  (result),
    .emit    (emit)
  );

  fam_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire && emit),
    .result (result),
    .ready  (out_ready),
    .valid  (out_valid),
    .held   (held)
  );

  assign frame_class    = held.frame_class;
  assign angles_updated = held.angles_updated;
  assign roll_out       = held.roll;
  assign pitch_out      = held.pitch;
  assign yaw_out        = held.yaw;

`ifndef SYNTH
  // A waiting result is never overwritten by the parser.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(fire && emit))
    else $error("result overwritten while stalled");

  // A held input word that was not parsed stays in place.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !fire) |=> (in_full && $stable(in_byte)))
    else $error("input word lost while stalled");

  // Angles are only marked refreshed for the angle class.
  a_upd_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && angles_updated) |-> (frame_class == fam_pkg::CLASS_ANGLES))
    else $error("angles_updated on a non-angle class");

  // A parsed word that ends a frame always raises out_valid next.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (fire && emit) |=> out_valid)
    else $error("emitted result not shown");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fam_parse.sv */
`default_nettype none

module fam_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output fam_pkg::result_t      result,
  output logic                  emit
);

  typedef enum logic [2:0] {
    HUNT   = 3'd0,
    SYNC2  = 3'd1,
    CLS_LO = 3'd2,
    CLS_HI = 3'd3,
    LEN    = 3'd4,
    BODY   = 3'd5
  } phase_t;

  phase_t                           phase, phase_next;
  logic [fam_pkg::COUNT_W-1:0]      count, count_next;
  logic [15:0]                      class_word, class_word_next;
  logic [15:0]                      length_word, length_word_next;
  logic [7:0]                       head [fam_pkg::HEAD_DEPTH];
  logic [7:0]                       head_next [fam_pkg::HEAD_DEPTH];
  logic [fam_pkg::ANGLE_W-1:0]      angles [3];
  logic [fam_pkg::ANGLE_W-1:0]      angles_next [3];
  logic [fam_pkg::COUNT_W-1:0]      offset;
  logic [fam_pkg::COUNT_W-1:0]      frame_end;
  logic                             in_head;

  assign offset    = count - fam_pkg::COUNT_W'(fam_pkg::HEAD_BYTES);
  assign in_head   = (count >= fam_pkg::COUNT_W'(fam_pkg::HEAD_BYTES)) &&
                     (count < fam_pkg::COUNT_W'(fam_pkg::HEAD_BYTES + fam_pkg::HEAD_DEPTH));
  assign frame_end = {1'b0, length_word} +
                     fam_pkg::COUNT_W'(fam_pkg::HEAD_BYTES + fam_pkg::TRAIL_BYTES);

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    class_word_next  = class_word;
    length_word_next = length_word;
    head_next        = head;
    angles_next      = angles;
    emit             = 1'b0;
    case (phase)
      HUNT: begin
        if (rx_byte == fam_pkg::SYNC_FIRST) phase_next = SYNC2;
      end
      SYNC2: begin
        // A wrong second byte drops back to the hunt without a second look.
        if (rx_byte == fam_pkg::SYNC_SECOND) begin
          count_next = '0;
          phase_next = CLS_LO;
        end else begin
          phase_next = HUNT;
        end
      end
      CLS_LO: begin
        class_word_next = {class_word[15:8], rx_byte};
        count_next      = fam_pkg::COUNT_W'(1);
        phase_next      = CLS_HI;
      end
      CLS_HI: begin
        class_word_next = {rx_byte, class_word[7:0]};
        count_next      = fam_pkg::COUNT_W'(2);
        phase_next      = LEN;
      end
      LEN: begin
        if (count == fam_pkg::COUNT_W'(2)) begin
          length_word_next = {length_word[15:8], rx_byte};
          count_next       = fam_pkg::COUNT_W'(3);
        end else begin
          length_word_next = {rx_byte, length_word[7:0]};
          count_next       = fam_pkg::COUNT_W'(fam_pkg::HEAD_BYTES);
          phase_next       = BODY;
        end
      end
      BODY: begin
        if (in_head) head_next[offset[fam_pkg::HEAD_IDX_W-1:0]] = rx_byte;
        count_next = count + fam_pkg::COUNT_W'(1);
        if (count_next == frame_end) begin
          emit       = 1'b1;
          phase_next = HUNT;
          if (class_word == fam_pkg::CLASS_ANGLES) begin
            angles_next[0] = {head_next[3], head_next[2], head_next[1], head_next[0]};
            angles_next[1] = {head_next[7], head_next[6], head_next[5], head_next[4]};
            angles_next[2] = {head_next[11], head_next[10], head_next[9], head_next[8]};
          end
        end
      end
      default: begin
        phase_next = HUNT;
      end
    endcase
  end

  assign result.frame_class    = class_word;
  assign result.angles_updated = (class_word == fam_pkg::CLASS_ANGLES);
  assign result.roll           = angles_next[0];
  assign result.pitch          = angles_next[1];
  assign result.yaw            = angles_next[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= HUNT;
      count       <= '0;
      class_word  <= '0;
      length_word <= '0;
      for (int i = 0; i < fam_pkg::HEAD_DEPTH; i++) head[i] <= '0;
      for (int i = 0; i < 3; i++) angles[i] <= '0;
    end else if (step) begin
      phase       <= phase_next;
      count       <= count_next;
      class_word  <= class_word_next;
      length_word <= length_word_next;
      head        <= head_next;
      angles      <= angles_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fam_out.sv */
`default_nettype none

module fam_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire fam_pkg::result_t  result,
  input  wire logic              ready,
  output logic                   valid,
  output fam_pkg::result_t       held
);

  // Hold the result until taken; a new one may replace it on the taking edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= result;
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Bench for the attitude message deframer.
// A byte-level parser model tracks the sync hunt, header, payload head and held
// angle words. Every word the DUT accepts advances that model, and each frame it
// completes queues one expected result. The checker compares DUT results field
// by field, in order, against that queue.
module testbench;

  // Parser phases, in the block's own encoding.
  typedef enum logic [2:0] {
    HUNT_SYNC_B  = 3'd0,
    HUNT_SYNC_D  = 3'd1,
    CLASS_LOW    = 3'd2,
    CLASS_HIGH   = 3'd3,
    LENGTH_BYTES = 3'd4,
    BODY_BYTES   = 3'd5
  } parse_phase_t;

  localparam int HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic [15:0] frame_class;
  logic angles_updated;
  logic signed [31:0] roll_out;
  logic signed [31:0] pitch_out;
  logic signed [31:0] yaw_out;

  framed_attitude_message_deframer DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_class    (frame_class),
    .angles_updated (angles_updated),
    .roll_out       (roll_out),
    .pitch_out      (pitch_out),
    .yaw_out        (yaw_out)
  );

  // Parser model state; it mirrors the block after every accepted word.
  parse_phase_t     prs_phase;
  logic [16:0]      prs_pos;
  logic [15:0]      prs_class;
  logic [15:0]      prs_length;
  logic [7:0]       prs_head [fam_pkg::HEAD_DEPTH];
  logic [31:0]      prs_angles [3];

  fam_pkg::result_t pending_frames [$];  // results owed by the DUT, oldest first
  logic [7:0]       frame_body [$];      // payload and checksum for the next frame

  // Traffic shaping knobs, shared between test tasks and the receiver.
  bit  idle_in;
  bit  idle_out;
  int  hold_off_left;

  // Run statistics.
  int  mismatches;
  int  words_in;
  int  frames_checked;
  int  angle_reloads;
  int  longest_length;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the DUT hangs on either channel.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Advance the parser model by one accepted word; queue a result at frame end.
  function automatic void parse_byte(input logic [7:0] b);
    fam_pkg::result_t done;
    case (prs_phase)
      HUNT_SYNC_B: begin
        if (b == fam_pkg::SYNC_FIRST) prs_phase = HUNT_SYNC_D;
      end
      HUNT_SYNC_D: begin
        // A wrong second sync word drops back to the hunt; it is never a new 'b'.
        if (b == fam_pkg::SYNC_SECOND) begin
          prs_pos   = '0;
          prs_phase = CLASS_LOW;
        end else begin
          prs_phase = HUNT_SYNC_B;
        end
      end
      CLASS_LOW: begin
        prs_class[7:0] = b;
        prs_pos        = 17'd1;
        prs_phase      = CLASS_HIGH;
      end
      CLASS_HIGH: begin
        prs_class[15:8] = b;
        prs_pos         = 17'd2;
        prs_phase       = LENGTH_BYTES;
      end
      LENGTH_BYTES: begin
        if (prs_pos == 17'd2) begin
          prs_length[7:0] = b;
          prs_pos         = 17'd3;
        end else begin
          prs_length[15:8] = b;
          prs_pos          = 17'(fam_pkg::HEAD_BYTES);
          prs_phase        = BODY_BYTES;
        end
      end
      BODY_BYTES: begin
        // Keep frame positions 4..15 only, checksum words included; the rest
        // of a long frame is just counted.
        if (prs_pos >= 17'(fam_pkg::HEAD_BYTES) &&
            prs_pos < 17'(fam_pkg::HEAD_BYTES + fam_pkg::HEAD_DEPTH))
          prs_head[4'(prs_pos - 17'(fam_pkg::HEAD_BYTES))] = b;
        prs_pos = prs_pos + 17'd1;
        if (int'(prs_pos) ==
            int'(prs_length) + fam_pkg::HEAD_BYTES + fam_pkg::TRAIL_BYTES) begin
          prs_phase = HUNT_SYNC_B;
          done.frame_class    = prs_class;
          done.angles_updated = (prs_class == fam_pkg::CLASS_ANGLES);
          if (done.angles_updated) begin
            for (int k = 0; k < 3; k++)
              prs_angles[k] = {prs_head[4*k+3], prs_head[4*k+2],
                               prs_head[4*k+1], prs_head[4*k]};
          end
          done.roll  = prs_angles[0];
          done.pitch = prs_angles[1];
          done.yaw   = prs_angles[2];
          pending_frames.push_back(done);
        end
      end
      default: prs_phase = HUNT_SYNC_B;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one word, holding it until the DUT takes it. Ends on the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_in && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_in++;
    parse_byte(b);
  endtask

  // Send a whole frame; body words not preset in frame_body are random.
  task automatic send_frame(input logic [15:0] cls, input logic [15:0] len);
    int total;
    total = int'(len) + fam_pkg::TRAIL_BYTES;
    if (int'(len) > longest_length) longest_length = int'(len);
    send_byte(fam_pkg::SYNC_FIRST);
    send_byte(fam_pkg::SYNC_SECOND);
    send_byte(cls[7:0]);
    send_byte(cls[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < total; i++)
      send_byte(i < frame_body.size() ? frame_body[i] : 8'($urandom));
    frame_body.delete();
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) frame_body.push_back(w[8*i +: 8]);
  endtask

  // Stop offering and hold until every owed result has come back.
  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() > 0) @(posedge clk);
  endtask

  // Receiver: long hold-offs take priority, then random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_out && $urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    fam_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result, class %h", frame_class));
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (want.angles_updated) angle_reloads++;
        if (frame_class !== want.frame_class)
          report_mismatch($sformatf("frame_class %h, want %h",
                                    frame_class, want.frame_class));
        if (angles_updated !== want.angles_updated)
          report_mismatch($sformatf("angles_updated %b, want %b (class %h)",
                                    angles_updated, want.angles_updated,
                                    want.frame_class));
        if (roll_out !== want.roll)
          report_mismatch($sformatf("roll_out %h, want %h", roll_out, want.roll));
        if (pitch_out !== want.pitch)
          report_mismatch($sformatf("pitch_out %h, want %h", pitch_out, want.pitch));
        if (yaw_out !== want.yaw)
          report_mismatch($sformatf("yaw_out %h, want %h", yaw_out, want.yaw));
      end
    end
  end

  // Noise around the sync: a wrong second word must not count as a new 'b'.
  task automatic test_sync_hunt;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(fam_pkg::SYNC_SECOND);
    send_byte(fam_pkg::SYNC_FIRST);
    send_byte(fam_pkg::SYNC_FIRST);
    send_byte(fam_pkg::SYNC_SECOND);
    send_frame(16'h1234, 16'd0);
  endtask

  // Angle frames with the extreme signed values, then small ones.
  task automatic test_angle_extremes;
    push_word(32'h8000_0000);
    push_word(32'h7FFF_FFFF);
    push_word(32'hFFFF_FFFF);
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    send_frame(fam_pkg::CLASS_ANGLES, 16'd12);
    push_word(32'h0000_0000);
    push_word(32'h0000_0001);
    push_word(32'hFFFF_FFFE);
    send_frame(fam_pkg::CLASS_ANGLES, 16'd12);
  endtask

  // Short angle frame: checksum lands in the head, the rest keeps old words.
  task automatic test_short_angle_frame;
    frame_body = '{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h99};
    send_frame(fam_pkg::CLASS_ANGLES, 16'd3);
    send_frame(fam_pkg::CLASS_ANGLES, 16'd0);
  endtask

  // Non-angle classes and a frame longer than the stored head.
  task automatic test_class_and_length;
    send_frame(16'hFFFF, 16'd0);
    send_frame(16'h0100, 16'd12);
    send_frame(16'h00FF, 16'd5);
    send_frame(fam_pkg::CLASS_ANGLES, 16'd40);
  endtask

  // Mostly well-formed frames with random content, some noise and broken syncs.
  task automatic test_random_frames(input int target_words);
    int start;
    logic [15:0] cls;
    logic [15:0] len;
    int pick;
    start = words_in;
    while (words_in - start < target_words) begin
      // Leave some frames without idling on one side or both.
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 4)       cls = fam_pkg::CLASS_ANGLES;
      else if (pick == 4) cls = 16'hFFFF;
      else if (pick == 5) cls = {8'h00, 8'($urandom)};
      else if (pick == 6) cls = {8'($urandom), 8'h00};
      else                cls = 16'($urandom);
      if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(17, 48));
      else                           len = 16'($urandom_range(0, 16));
      send_frame(cls, len);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Stray word that never opens a sync.
        send_byte(8'(fam_pkg::SYNC_FIRST + 8'($urandom_range(1, 255))));
      end else if (pick == 1) begin
        // Broken sync: 'b' followed by anything but 'd'.
        send_byte(fam_pkg::SYNC_FIRST);
        send_byte(8'(fam_pkg::SYNC_SECOND + 8'($urandom_range(1, 255))));
      end else if (pick == 2) begin
        send_byte(fam_pkg::SYNC_FIRST);
        send_byte(fam_pkg::SYNC_FIRST);
        send_byte(fam_pkg::SYNC_SECOND);
      end
    end
  endtask

  // Hold the receiver off while short frames keep coming, so the DUT backs up.
  task automatic test_output_hold_off;
    idle_in  = 1'b0;
    idle_out = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 12; i++) send_frame(16'($urandom_range(0, 1)), 16'd0);
  endtask

  // Long frame: length high byte in use, far past the stored head.
  task automatic test_longest_frame;
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_frame(fam_pkg::CLASS_ANGLES, 16'd300);
  endtask

  // Closing stretch without any idling.
  task automatic test_steady_stream;
    idle_in  = 1'b0;
    idle_out = 1'b0;
    for (int i = 0; i < 10; i++)
      send_frame($urandom_range(0, 1) ? fam_pkg::CLASS_ANGLES : 16'($urandom),
                 16'($urandom_range(0, 14)));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    out_ready = 1'b0;
    idle_in   = 1'b1;
    idle_out  = 1'b1;
    hold_off_left = 0;
    mismatches     = 0;
    words_in       = 0;
    frames_checked = 0;
    angle_reloads  = 0;
    longest_length = 0;
    prs_phase  = HUNT_SYNC_B;
    prs_pos    = '0;
    prs_class  = '0;
    prs_length = '0;
    for (int i = 0; i < fam_pkg::HEAD_DEPTH; i++) prs_head[i] = 8'h00;
    for (int i = 0; i < 3; i++) prs_angles[i] = 32'h0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_sync_hunt;
    test_angle_extremes;
    test_short_angle_frame;
    test_class_and_length;
    wait_drained;
    test_random_frames(450);
    wait_drained;
    test_output_hold_off;
    wait_drained;
    test_random_frames(350);
    wait_drained;
    test_longest_frame;
    test_steady_stream;

    wait_drained;
    repeat (8) @(posedge clk);

    $display("Covered %0d words in, %0d frames checked, %0d of them angle reloads.",
             words_in, frames_checked, angle_reloads);
    $display("Longest payload %0d words; broken syncs, short and long frames, stalls.",
             longest_length);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
